// File: rtl/core/lru_pkg.sv
// ----------------------------------------------------------------------------
// lru_pkg: shared constants and helpers for the LRU page replacement stack
// Sizes of the stack, page and counter fields, and the frame count clamp.
// ----------------------------------------------------------------------------
package lru_pkg;

  // Stack geometry
  localparam int unsigned MAX_FRAMES  = 16;
  localparam int unsigned PAGE_BITS   = 8;
  localparam int unsigned FRAME_IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned FRAME_CNT_W = $clog2(MAX_FRAMES + 1);

  // Port field widths
  localparam int unsigned PAGE_W  = 8;
  localparam int unsigned CFG_W   = 5;
  localparam int unsigned FAULT_W = 16;

  // Frame count after reset
  localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(4);

  typedef logic [PAGE_BITS-1:0]   page_t;
  typedef logic [FRAME_IDX_W-1:0] frame_idx_t;
  typedef logic [FRAME_CNT_W-1:0] frame_cnt_t;

  // Clamp a programmed frame count into 1..MAX_FRAMES
  function automatic frame_cnt_t clamp_frames(input logic [CFG_W-1:0] value);
    frame_cnt_t res;
    if (value == '0) begin
      res = frame_cnt_t'(1);
    end else if (32'(value) > MAX_FRAMES) begin
      res = frame_cnt_t'(MAX_FRAMES);
    end else begin
      res = frame_cnt_t'(value);
    end
    return res;
  endfunction

endpackage

// File: rtl/core/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement: LRU page replacement stack
// Tracks resident pages in LRU order, reports hit, eviction and fault count.
// ----------------------------------------------------------------------------
// Usage:
//   A page reference beat is taken on a rising edge with start_i high and
//   busy_o low. busy_o is always low: one reference per cycle is taken.
//   restart_i on a beat empties the stack, clears the fault count and loads
//   the frame count from the config register before the reference is used.
//   The result beat of a reference is produced through two registers
//   (input register, then compare/shift into the result register) and is
//   shown for one cycle with result_valid_o high. The receiver cannot stall.
//   Throughput is one reference per cycle; all slot compares and the stack
//   shift are combinational between the two registers.
//   cfg_we_i/cfg_wdata_i write the frame count; it takes effect on the next
//   restart. After reset the stack is empty, the fault count is zero and
//   four frames are in use.
// ----------------------------------------------------------------------------
module lru_page_replacement
  import lru_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [PAGE_W-1:0]  page_number_i,
  input  logic               restart_i,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  output logic               result_valid_o,
  output logic               hit_o,
  output logic               evicted_valid_o,
  output logic [PAGE_W-1:0]  evicted_page_o,
  output logic [FAULT_W-1:0] fault_count_o
);

  // Config and stack state
  logic [CFG_W-1:0]   frames_cfg_q;
  frame_cnt_t         active_q, active_d;
  page_t              page_q  [MAX_FRAMES];
  page_t              page_d  [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid_q, valid_d;
  logic [FAULT_W-1:0] faults_q, faults_d;

  // Input register
  logic               in_valid_q;
  page_t              in_page_q;
  logic               in_restart_q;

  // Result register
  logic               result_valid_q;
  logic               hit_q, hit_d;
  logic               ev_valid_q, ev_valid_d;
  logic [PAGE_W-1:0]  ev_page_q, ev_page_d;
  logic [FAULT_W-1:0] fault_out_q;

  // Working signals
  page_t              page_eff [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid_eff;
  frame_cnt_t         active_eff;
  logic [FAULT_W-1:0] faults_eff;
  logic [MAX_FRAMES-1:0] match;
  frame_idx_t         where;
  frame_idx_t         from_idx;
  frame_idx_t         top_idx;
  logic               accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_cfg_q <= FRAMES_RESET;
    end else if (cfg_we_i) begin
      frames_cfg_q <= cfg_wdata_i;
    end
  end

  // Input register: valid needs reset, payload does not
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_page_q    <= page_number_i[PAGE_BITS-1:0];
      in_restart_q <= restart_i;
    end
  end

  // State as seen by this reference, after an optional restart
  always_comb begin
    for (int f = 0; f < MAX_FRAMES; f++) begin
      page_eff[f] = page_q[f];
    end
    valid_eff  = in_restart_q ? '0 : valid_q;
    active_eff = in_restart_q ? clamp_frames(frames_cfg_q) : active_q;
    faults_eff = in_restart_q ? '0 : faults_q;
  end

  // Parallel compare over all slots in use
  always_comb begin
    for (int f = 0; f < MAX_FRAMES; f++) begin
      match[f] = valid_eff[f] && (page_eff[f] == in_page_q) &&
                 (frame_cnt_t'(f) < active_eff);
    end
  end

  // Highest matching slot
  always_comb begin
    where = '0;
    for (int f = 0; f < MAX_FRAMES; f++) begin
      if (match[f]) begin
        where = frame_idx_t'(f);
      end
    end
  end

  // Shift slots from..top-1 down by one and push the page on top
  always_comb begin
    hit_d    = |match;
    top_idx  = frame_idx_t'(active_eff - frame_cnt_t'(1));
    from_idx = hit_d ? where : '0;
    for (int f = 0; f < MAX_FRAMES; f++) begin
      page_d[f]  = page_eff[f];
      valid_d[f] = valid_eff[f];
    end
    for (int f = 0; f < MAX_FRAMES - 1; f++) begin
      if ((frame_idx_t'(f) >= from_idx) && (frame_idx_t'(f) < top_idx)) begin
        page_d[f]  = page_eff[f+1];
        valid_d[f] = valid_eff[f+1];
      end
    end
    page_d[top_idx]  = in_page_q;
    valid_d[top_idx] = 1'b1;
  end

  // Eviction and fault count
  always_comb begin
    ev_valid_d = !hit_d && valid_eff[0];
    ev_page_d  = ev_valid_d ? PAGE_W'(page_eff[0]) : '0;
    faults_d   = faults_eff;
    if (!hit_d && (faults_eff != '1)) begin
      faults_d = faults_eff + FAULT_W'(1);
    end
    active_d = active_eff;
  end

  // Stack control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      faults_q <= '0;
      active_q <= clamp_frames(FRAMES_RESET);
    end else if (in_valid_q) begin
      valid_q  <= valid_d;
      faults_q <= faults_d;
      active_q <= active_d;
    end
  end

  // Stack page storage, qualified by the valid bits
  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      for (int f = 0; f < MAX_FRAMES; f++) begin
        page_q[f] <= page_d[f];
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      hit_q       <= hit_d;
      ev_valid_q  <= ev_valid_d;
      ev_page_q   <= ev_page_d;
      fault_out_q <= faults_d;
    end
  end

  assign result_valid_o  = result_valid_q;
  assign hit_o           = hit_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;
  assign fault_count_o   = fault_out_q;

  // Assertions
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q |=> result_valid_q)
    else $error("result beat missing after a reference");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_q && hit_q) |-> (!ev_valid_q && (ev_page_q == '0)))
    else $error("eviction reported on a hit");

  a_miss_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_q && !hit_q) |-> (fault_out_q != '0))
    else $error("miss left the fault count at zero");

  a_unique_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q |-> $onehot0(match))
    else $error("page resident in more than one slot");

  a_active_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q != '0) && (32'(active_q) <= MAX_FRAMES))
    else $error("active frame count out of range");

endmodule

// File: tb/sv/lru_checker.sv
// ----------------------------------------------------------------------------
// lru_checker: scoreboard for the LRU page replacement stack
// Watches the reference, config and result channels. Keeps its own copy of
// the LRU stack, predicts one outcome per accepted reference beat and
// compares every result beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module lru_checker
  import lru_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [PAGE_W-1:0]  page_number_i,
  input  logic               restart_i,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  input  logic               result_valid_i,
  input  logic               hit_i,
  input  logic               evicted_valid_i,
  input  logic [PAGE_W-1:0]  evicted_page_i,
  input  logic [FAULT_W-1:0] fault_count_i,
  output int                 mismatch_cnt_o,
  output int                 pending_o
);

  typedef struct packed {
    logic               hit;
    logic               ev_valid;
    logic [PAGE_W-1:0]  ev_page;
    logic [FAULT_W-1:0] faults;
  } lru_outcome_t;

  // Shadow of the frame count register and the live stack
  logic [CFG_W-1:0]   frames_cfg;
  int unsigned        frames_live;
  logic [PAGE_W-1:0]  slot_page [MAX_FRAMES];
  logic               slot_valid [MAX_FRAMES];
  logic [FAULT_W-1:0] faults_seen;
  lru_outcome_t       outcome_q [$];

  // Empty every slot, clear faults and load the clamped frame count
  task automatic empty_stack();
    for (int s = 0; s < MAX_FRAMES; s++) begin
      slot_page[s]  = '0;
      slot_valid[s] = 1'b0;
    end
    faults_seen = '0;
    if (frames_cfg == '0) begin
      frames_live = 1;
    end else if (int'(frames_cfg) > MAX_FRAMES) begin
      frames_live = MAX_FRAMES;
    end else begin
      frames_live = int'(frames_cfg);
    end
  endtask

  // One page reference: LRU search, shift toward slot 0, push as most recent
  task automatic reference_page(input logic [PAGE_W-1:0] pg, input logic clear,
                                output lru_outcome_t res);
    int unsigned hit_slot;
    int unsigned top;
    bit          found;
    res      = '0;
    found    = 1'b0;
    hit_slot = 0;
    if (clear) empty_stack();
    for (int unsigned s = 0; s < frames_live; s++) begin
      if (slot_valid[s] && slot_page[s] == pg) begin
        found    = 1'b1;
        hit_slot = s;
      end
    end
    if (!found) begin
      if (faults_seen != '1) faults_seen++;
      if (slot_valid[0]) begin
        res.ev_valid = 1'b1;
        res.ev_page  = slot_page[0];
      end
    end
    // a miss drops slot 0, a hit drops the hit slot
    top = frames_live - 1;
    for (int unsigned s = hit_slot; s < top; s++) begin
      slot_page[s]  = slot_page[s + 1];
      slot_valid[s] = slot_valid[s + 1];
    end
    slot_page[top]  = pg;
    slot_valid[top] = 1'b1;
    res.hit    = found;
    res.faults = faults_seen;
  endtask

  task automatic note_mismatch(input string what, input lru_outcome_t want,
                               input lru_outcome_t got);
    if (mismatch_cnt_o < 10) begin
      $display("%0t: %s: exp hit=%0b ev=%0b/%0d faults=%0d, got hit=%0b ev=%0b/%0d faults=%0d",
               $realtime, what, want.hit, want.ev_valid, want.ev_page, want.faults,
               got.hit, got.ev_valid, got.ev_page, got.faults);
    end
    mismatch_cnt_o++;
  endtask

  // Monitor: results are checked before the same-edge reference is predicted
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    lru_outcome_t want;
    lru_outcome_t got;
    if (!rst_ni) begin
      frames_cfg     = FRAMES_RESET;
      empty_stack();
      outcome_q.delete();
      mismatch_cnt_o = 0;
    end else begin
      if (result_valid_i) begin
        got = {hit_i, evicted_valid_i, evicted_page_i, fault_count_i};
        if (outcome_q.size() == 0) begin
          note_mismatch("result beat with nothing outstanding", '0, got);
        end else begin
          want = outcome_q.pop_front();
          if (got !== want) note_mismatch("result beat differs", want, got);
        end
      end
      if (start_i && !busy_i) begin
        reference_page(page_number_i, restart_i, want);
        outcome_q.push_back(want);
      end
      if (cfg_we_i) frames_cfg = cfg_wdata_i;
    end
    pending_o = outcome_q.size();
  end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for the LRU page replacement stack
// Drives directed and random page reference beats with random idle gaps,
// reprograms the frame count between phases, runs a single-frame stretch
// of alternating pages where every beat faults, and reports the verdict
// from the checker's mismatch count.
// ----------------------------------------------------------------------------
module testbench;
  import lru_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ALT_REFS       = 16;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               start_i       = 1'b0;
  logic [PAGE_W-1:0]  page_number_i = '0;
  logic               restart_i     = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata_i   = '0;
  logic               busy_o;
  logic               result_valid_o;
  logic               hit_o;
  logic               evicted_valid_o;
  logic [PAGE_W-1:0]  evicted_page_o;
  logic [FAULT_W-1:0] fault_count_o;
  int                 mismatch_cnt;
  int                 pending;
  int                 idle_cycles = 0;

  lru_page_replacement u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .page_number_i  (page_number_i),
    .restart_i      (restart_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .hit_o          (hit_o),
    .evicted_valid_o(evicted_valid_o),
    .evicted_page_o (evicted_page_o),
    .fault_count_o  (fault_count_o)
  );

  lru_checker u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .page_number_i  (page_number_i),
    .restart_i      (restart_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_i (result_valid_o),
    .hit_i          (hit_o),
    .evicted_valid_i(evicted_valid_o),
    .evicted_page_i (evicted_page_o),
    .fault_count_i  (fault_count_o),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("lru_page_replacement: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one reference beat; busy is sampled at the falling edge
  task automatic send_ref(input logic [PAGE_W-1:0] pg, input logic clr);
    start_i       <= 1'b1;
    page_number_i <= pg;
    restart_i     <= clr;
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Mostly back-to-back or short gaps, now and then a long one
  function automatic int pick_gap(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Wait until every outstanding result beat has come back
  task automatic drain();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Random phase: pages drawn mostly from a window a little wider than the
  // frame count so hits and evictions both happen
  task automatic run_phase(input logic [CFG_W-1:0] frames, input int n_refs);
    int                span;
    int                r;
    bit                steady;
    logic [PAGE_W-1:0] base;
    logic [PAGE_W-1:0] pg;
    logic [PAGE_W-1:0] last_pg;
    drain();
    write_frames(frames);
    if (frames == '0) span = 1;
    else if (int'(frames) > MAX_FRAMES) span = MAX_FRAMES;
    else span = int'(frames);
    span    = span + $urandom_range(0, 3);
    base    = PAGE_W'($urandom_range(0, 255));
    steady  = ($urandom_range(0, 3) == 0);
    last_pg = base;
    for (int k = 0; k < n_refs; k++) begin
      r = $urandom_range(0, 99);
      if (r < 80) pg = base + PAGE_W'($urandom_range(0, span));
      else if (r < 95) pg = PAGE_W'($urandom_range(0, 255));
      else pg = last_pg;
      idle_gap(pick_gap(steady));
      send_ref(pg, (k == 0) || ($urandom_range(0, 99) < 3));
      last_pg = pg;
    end
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0]  frame_plan [8];
    logic [PAGE_W-1:0] pg;
    frame_plan = '{5'd16, 5'd1, 5'd17, 5'd2, 5'd5, 5'd31, 5'd8, 5'd3};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Four frames after reset: page 0 must miss against the empty slots
    send_ref(8'h00, 1'b0);
    send_ref(8'hFF, 1'b0);
    send_ref(8'h55, 1'b0);
    send_ref(8'hAA, 1'b0);
    send_ref(8'h01, 1'b0);   // evicts page 0
    send_ref(8'hFF, 1'b0);   // hit on least recent
    send_ref(8'hFF, 1'b0);   // hit on most recent
    send_ref(8'hAA, 1'b0);   // hit in the middle
    send_ref(8'h80, 1'b0);   // miss with eviction

    // New frame count has no effect until restart; zero clamps to one
    drain();
    write_frames(5'd0);
    send_ref(8'h01, 1'b0);
    send_ref(8'h55, 1'b0);
    send_ref(8'h07, 1'b1);
    send_ref(8'h07, 1'b0);
    send_ref(8'h08, 1'b0);

    // Count above the stack depth clamps to the maximum
    drain();
    write_frames(5'd31);
    send_ref(8'hF0, 1'b1);
    send_ref(8'h0F, 1'b0);
    send_ref(8'hF0, 1'b0);

    // Random phases across the frame count range
    for (int p = 0; p < 10; p++) begin
      run_phase((p < 8) ? frame_plan[p] : CFG_W'($urandom_range(0, 31)), 70);
    end

    // One frame, alternating pages: every beat faults, each after the first evicts the other
    drain();
    write_frames(5'd1);
    pg = 8'hC3;
    for (int k = 0; k < ALT_REFS; k++) begin
      pg = (k % 2 == 0) ? 8'hC3 : 8'h3C;
      send_ref(pg, k == 0);
    end
    send_ref(pg, 1'b0);      // hit on the single frame
    send_ref(8'h99, 1'b0);   // miss on the single frame

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("lru_page_replacement: match");
    end else begin
      $display("lru_page_replacement: mismatch");
    end
    $finish;
  end

endmodule
